### hdl/dmrc_pkg.sv
// Shared types and constants for the direct-mapped read cache.
// Used by dmrc_front, dmrc_back and direct_mapped_read_cache.
`default_nettype none

package dmrc_pkg;

  localparam int NumLinesDef  = 8;
  localparam int LineBytesDef = 16;
  localparam int MemBytesDef  = 4096;

  localparam int AddrW       = 12;
  localparam int DataW       = 8;
  localparam int CountW      = 32;
  localparam int QueueDepth  = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } dmrc_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } dmrc_state_t;

  typedef struct packed {
    dmrc_op_t          op;
    logic [AddrW-1:0]  address;
    logic [DataW-1:0]  write_data;
  } dmrc_req_t;

endpackage

`default_nettype wire

### hdl/dmrc_front.sv
// Front end: takes requests, decodes the opcode and holds them in a short queue.
// Depends on dmrc_pkg.
`default_nettype none

module dmrc_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           opcode,
  input  wire  [dmrc_pkg::AddrW-1:0]    address,
  input  wire  [dmrc_pkg::DataW-1:0]    write_data,
  output logic                          q_valid,
  output dmrc_pkg::dmrc_req_t           q_req,
  input  wire                           q_pop
);

  localparam int Depth = dmrc_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dmrc_pkg::dmrc_req_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            push;
  dmrc_pkg::dmrc_req_t req_in;

  always_comb begin
    req_in.op         = opcode ? dmrc_pkg::OP_READ : dmrc_pkg::OP_WRITE;
    req_in.address    = address;
    req_in.write_data = write_data;
  end

  assign in_stall = (fill == CntW'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_req    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/dmrc_back.sv
// Back end: backing memory, line store, tags, counters and the result register.
// Depends on dmrc_pkg; fed by dmrc_front.
`default_nettype none

module dmrc_back #(
  parameter int NUM_LINES  = dmrc_pkg::NumLinesDef,
  parameter int LINE_BYTES = dmrc_pkg::LineBytesDef,
  parameter int MEM_BYTES  = dmrc_pkg::MemBytesDef
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            q_valid,
  input  dmrc_pkg::dmrc_req_t            q_req,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [7:0]                     read_data,
  output logic                           hit,
  output logic [4:0]                     tag,
  output logic [2:0]                     line_index,
  output logic [3:0]                     word_offset,
  output logic [7:0]                     block_number,
  output logic [dmrc_pkg::CountW-1:0]    miss_count,
  output logic [dmrc_pkg::CountW-1:0]    access_count
);

  localparam int DW     = dmrc_pkg::DataW;
  localparam int AW     = $clog2(MEM_BYTES);
  localparam int OW     = $clog2(LINE_BYTES);
  localparam int LW     = $clog2(NUM_LINES);
  localparam int BW     = AW - OW;
  localparam int TW     = BW - LW;
  localparam int Blocks = MEM_BYTES / LINE_BYTES;
  localparam int LineW  = LINE_BYTES * DW;
  localparam int CW     = dmrc_pkg::CountW;

  logic [LineW-1:0] backing [Blocks];
  logic [LineW-1:0] line_store [NUM_LINES];
  logic [TW-1:0]    tag_store [NUM_LINES];
  logic [NUM_LINES-1:0] line_valid;

  logic [LineW-1:0] mem_rd;
  logic [LineW-1:0] line_rd;
  logic [TW-1:0]    tag_rd;

  dmrc_pkg::dmrc_state_t state, state_next;

  logic [AW-1:0] q_addr;
  logic [OW-1:0] q_word;
  logic [BW-1:0] q_block;
  logic [LW-1:0] q_line;
  logic [TW-1:0] q_tag;

  logic [OW-1:0] cur_word;
  logic [BW-1:0] cur_block;
  logic [LW-1:0] cur_line;
  logic [TW-1:0] cur_tag;

  logic [CW-1:0] misses;
  logic [CW-1:0] accesses;
  logic [CW-1:0] misses_next;
  logic [CW-1:0] accesses_next;

  logic          out_free;
  logic          mem_we;
  logic          rd_en;
  logic          load_out;
  logic          fill_line;
  logic          is_hit;
  logic          res_hit;
  logic [DW-1:0] res_data;
  logic [OW-1:0] res_word;
  logic [BW-1:0] res_block;
  logic [LW-1:0] res_line;
  logic [TW-1:0] res_tag;

  assign q_addr   = AW'(q_req.address);
  assign q_word   = q_addr[OW-1:0];
  assign q_block  = q_addr[AW-1:OW];
  assign q_line   = q_block[LW-1:0];
  assign q_tag    = q_block[BW-1:LW];
  assign out_free = !out_valid || !out_stall;
  assign is_hit   = line_valid[cur_line] && (tag_rd == cur_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    fill_line     = 1'b0;
    res_hit       = 1'b0;
    res_data      = '0;
    res_word      = cur_word;
    res_block     = cur_block;
    res_line      = cur_line;
    res_tag       = cur_tag;
    misses_next   = misses;
    accesses_next = accesses;
    unique case (state)
      dmrc_pkg::ST_IDLE: begin
        res_word  = q_word;
        res_block = q_block;
        res_line  = q_line;
        res_tag   = q_tag;
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_req.op == dmrc_pkg::OP_WRITE) begin
            mem_we   = 1'b1;
            load_out = 1'b1;
          end else begin
            rd_en      = 1'b1;
            state_next = dmrc_pkg::ST_LOOKUP;
          end
        end
      end
      dmrc_pkg::ST_LOOKUP: begin
        if (out_free) begin
          load_out      = 1'b1;
          state_next    = dmrc_pkg::ST_IDLE;
          res_hit       = is_hit;
          fill_line     = !is_hit;
          accesses_next = (accesses == '1) ? accesses : accesses + 1'b1;
          if (!is_hit) begin
            misses_next = (misses == '1) ? misses : misses + 1'b1;
          end
          res_data = is_hit ? line_rd[cur_word*DW +: DW] : mem_rd[cur_word*DW +: DW];
        end
      end
      default: begin
        state_next = dmrc_pkg::ST_IDLE;
      end
    endcase
  end

  // backing store: one wide word per block, byte writes
  always_ff @(posedge clk) begin
    if (mem_we) begin
      backing[q_block][q_word*DW +: DW] <= q_req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rd <= backing[q_block];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_line) begin
      line_store[cur_line] <= mem_rd;
      tag_store[cur_line]  <= cur_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_rd <= line_store[q_line];
      tag_rd  <= tag_store[q_line];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_word  <= q_word;
      cur_block <= q_block;
      cur_line  <= q_line;
      cur_tag   <= q_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      misses     <= '0;
      accesses   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fill_line) begin
        line_valid[cur_line] <= 1'b1;
      end
      misses   <= misses_next;
      accesses <= accesses_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_data    <= res_data;
      hit          <= res_hit;
      tag          <= 5'(res_tag);
      line_index   <= 3'(res_line);
      word_offset  <= 4'(res_word);
      block_number <= 8'(res_block);
      miss_count   <= misses_next;
      access_count <= accesses_next;
    end
  end

endmodule

`default_nettype wire

### hdl/direct_mapped_read_cache.sv
// Top level of the direct-mapped read cache: front queue plus back end.
// Depends on dmrc_pkg, dmrc_front and dmrc_back.
//
// Read-only direct-mapped cache of NUM_LINES lines of LINE_BYTES bytes over a
// MEM_BYTES byte backing store (all powers of two). Opcode 0 stores a byte in
// the backing store without touching the cache; opcode 1 reads through the
// cache, filling the whole line from one wide backing word on a miss. Every
// request gives one result. A store is handled in the idle state of the back end;
// a read goes through a registered lookup of tag, line and backing word, then
// the hit/fill decision. A two-entry queue decouples input from the back end.
// No clearing pass after reset: line valid bits reset at once. Counters saturate.
`default_nettype none

module direct_mapped_read_cache #(
  parameter int NUM_LINES  = dmrc_pkg::NumLinesDef,
  parameter int LINE_BYTES = dmrc_pkg::LineBytesDef,
  parameter int MEM_BYTES  = dmrc_pkg::MemBytesDef
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            opcode,
  input  wire  [11:0]                    address,
  input  wire  [7:0]                     write_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [7:0]                     read_data,
  output logic                           hit,
  output logic [4:0]                     tag,
  output logic [2:0]                     line_index,
  output logic [3:0]                     word_offset,
  output logic [7:0]                     block_number,
  output logic [31:0]                    miss_count,
  output logic [31:0]                    access_count
);

  logic                q_valid;
  logic                q_pop;
  dmrc_pkg::dmrc_req_t q_req;

  dmrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .address    (address),
    .write_data (write_data),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  dmrc_back #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES),
    .MEM_BYTES  (MEM_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .hit          (hit),
    .tag          (tag),
    .line_index   (line_index),
    .word_offset  (word_offset),
    .block_number (block_number),
    .miss_count   (miss_count),
    .access_count (access_count)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_miss_le_access: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (miss_count <= access_count))
    else $error("more misses than reads");

  a_access_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (!out_valid || access_count >= $past(access_count)))
    else $error("read count went backwards");

endmodule

`default_nettype wire
